### rtl/core/color_bar_pattern_generator_assert.svh
// Assertion macros for the colour-bar pattern generator RTL.
`ifndef COLOR_BAR_PATTERN_GENERATOR_ASSERT_SVH
`define COLOR_BAR_PATTERN_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CBPG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbpg assertion failed");

// Next-cycle implication, checked outside reset.
`define CBPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbpg assertion failed");

`endif

### rtl/core/cbpg_pkg.sv
// Package: types, constants and colour tables of the colour-bar pattern generator.
package cbpg_pkg;

    localparam int C_COORD_W = 12;
    localparam int C_DIM_W   = 13;
    localparam int C_RGB_W   = 24;
    localparam int C_PROD_W  = 17;
    localparam int C_IDX_W   = 1;

    localparam logic [C_DIM_W-1:0] C_MAX_DIM      = 13'd4096;
    localparam logic [C_DIM_W-1:0] C_WIDTH_RESET  = 13'd640;
    localparam logic [C_DIM_W-1:0] C_HEIGHT_RESET = 13'd480;

    localparam logic [C_IDX_W-1:0] C_REG_WIDTH  = 1'b0;
    localparam logic [C_IDX_W-1:0] C_REG_HEIGHT = 1'b1;

    typedef logic [C_RGB_W-1:0]  t_rgb;
    typedef logic [C_PROD_W-1:0] t_prod;

    // Band edges scaled so a column compares without division:
    // x < (A / D) holds exactly when (x + 1) * D <= A.
    typedef struct packed {
        logic [C_DIM_W-1:0] width;
        logic [C_DIM_W-1:0] height;
        t_prod [3:0]        low_a;   // W*5k + 14, over 28
        t_prod [2:0]        low_b;   // W*(k+11) + 10, over 21
        t_prod [6:0]        seven;   // W*k + 3, over 7
    } t_geom;

    localparam t_rgb C_BAND_LOW [8] = '{
        24'h001d42, 24'hebebeb, 24'h2c005c, 24'h101010,
        24'h070707, 24'h101010, 24'h181818, 24'h101010
    };
    localparam t_rgb C_BAND_MID [7] = '{
        24'h0f0fb4, 24'h101010, 24'hb410b4, 24'h101010,
        24'h0db4b4, 24'h101010, 24'hb4b4b4
    };
    localparam t_rgb C_BAND_TOP [7] = '{
        24'hb4b4b4, 24'hb4b40c, 24'h0db4b4, 24'h0db40c,
        24'hb410b4, 24'hb40f0e, 24'h0f0fb4
    };

endpackage

### rtl/core/cbpg_cfg.sv
// Frame size registers and the registered band edges derived from them.
module cbpg_cfg import cbpg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [C_IDX_W-1:0] i_cfg_index,
    input  logic [C_DIM_W-1:0] i_cfg_data,
    output t_geom              o_geom
);

    logic [C_DIM_W-1:0] r_width;
    logic [C_DIM_W-1:0] r_height;
    t_geom              r_geom;
    t_geom              n_geom;
    logic [C_DIM_W-1:0] w_clamped;
    t_prod              w_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= C_WIDTH_RESET;
            r_height <= C_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                C_REG_WIDTH:  r_width  <= i_cfg_data;
                C_REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_clamped = (r_width > C_MAX_DIM) ? C_MAX_DIM : r_width;
    assign w_ext     = C_PROD_W'(w_clamped);

    // Constant multiples only: each is a short shift-add.
    always_comb begin
        n_geom.width  = w_clamped;
        n_geom.height = (r_height > C_MAX_DIM) ? C_MAX_DIM : r_height;
        for (int k = 0; k < 4; k++) begin
            n_geom.low_a[k] = C_PROD_W'(w_ext * C_PROD_W'(5 * (k + 1)) + C_PROD_W'(14));
        end
        for (int k = 0; k < 3; k++) begin
            n_geom.low_b[k] = C_PROD_W'(w_ext * C_PROD_W'(k + 16) + C_PROD_W'(10));
        end
        for (int k = 0; k < 7; k++) begin
            n_geom.seven[k] = C_PROD_W'(w_ext * C_PROD_W'(k + 1) + C_PROD_W'(3));
        end
    end

    always_ff @(posedge i_clk) begin
        r_geom <= n_geom;
    end

    assign o_geom = r_geom;

endmodule

### rtl/core/cbpg_shade.sv
// Band decision and colour lookup for one pixel, with the result register.
module cbpg_shade import cbpg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic [C_COORD_W-1:0] i_column,
    input  logic [C_COORD_W-1:0] i_row,
    input  t_geom                i_geom,
    output t_rgb                 o_color,
    output logic                 o_in_frame
);

    t_prod      x1;
    t_prod      y1;
    t_prod      x28;
    t_prod      x21;
    t_prod      x7;
    logic [2:0] low_sel;
    logic [2:0] sev_sel;
    logic       inside_frame;
    logic       in_low;
    logic       in_mid;
    t_rgb       n_color;
    t_rgb       r_color;
    logic       r_in_frame;

    assign x1  = C_PROD_W'(i_column) + C_PROD_W'(1);
    assign y1  = C_PROD_W'(i_row) + C_PROD_W'(1);
    assign x28 = C_PROD_W'(x1 * C_PROD_W'(28));
    assign x21 = C_PROD_W'(x1 * C_PROD_W'(21));
    assign x7  = C_PROD_W'(x1 * C_PROD_W'(7));

    assign inside_frame = (C_DIM_W'(i_column) < i_geom.width)
                       && (C_DIM_W'(i_row) < i_geom.height);
    // row < h/4 and row < h/3 without dividing
    assign in_low = C_PROD_W'(y1 * C_PROD_W'(4)) <= C_PROD_W'(i_geom.height);
    assign in_mid = C_PROD_W'(y1 * C_PROD_W'(3)) <= C_PROD_W'(i_geom.height);

    // Walk from the last edge back so the first edge past the column wins.
    always_comb begin
        low_sel = 3'd7;
        for (int k = 2; k >= 0; k--) begin
            if (x21 <= i_geom.low_b[k]) begin
                low_sel = 3'(k + 4);
            end
        end
        for (int k = 3; k >= 0; k--) begin
            if (x28 <= i_geom.low_a[k]) begin
                low_sel = 3'(k);
            end
        end
        sev_sel = 3'd6;
        for (int k = 6; k >= 0; k--) begin
            if (x7 <= i_geom.seven[k]) begin
                sev_sel = 3'(k);
            end
        end
    end

    always_comb begin
        if (!inside_frame) begin
            n_color = '0;
        end else if (in_low) begin
            n_color = C_BAND_LOW[low_sel];
        end else if (in_mid) begin
            n_color = C_BAND_MID[sev_sel];
        end else begin
            n_color = C_BAND_TOP[sev_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_color    <= n_color;
            r_in_frame <= inside_frame;
        end
    end

    assign o_color    = r_color;
    assign o_in_frame = r_in_frame;

endmodule

### rtl/core/color_bar_pattern_generator.sv
// Top level of the colour-bar pattern generator: stream ports, input register, assertions.
`include "color_bar_pattern_generator_assert.svh"

// Colour-bar test pattern source. Each input transfer carries a pixel
// coordinate (column from the left, row counted from the bottom of the frame)
// and yields exactly one output transfer with the 24-bit RGB colour of the
// standard bar pattern and an in-frame flag; coordinates outside the
// configured frame give colour zero with the flag clear. The block takes one
// transfer per clock while the output is not back-pressured. A coordinate
// waits in the input register while the band compare and colour table fill
// the result register, from which its result is offered. Back-pressure on
// the output stalls both stages; a new coordinate is still taken while a
// finished result waits, provided the input register is
// empty or moves on in that same cycle. Frame width and height are written
// through the plain register port (index 0 width, index 1 height, values
// above 4096 act as 4096, zero puts every pixel outside the frame). The band
// edges are recomputed from the size registers every cycle, so write the
// size only while no pixel is in flight; a pixel may follow the write in the
// very next cycle.
module color_bar_pattern_generator import cbpg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [C_IDX_W-1:0] i_cfg_index,
    input  logic [C_DIM_W-1:0] i_cfg_data,
    // coordinate stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [23:0]        s_axis_tdata,   // [11:0] column, [23:12] row
    // pixel stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [23:0]        m_axis_tdata,   // [23:0] color
    output logic               m_axis_tuser    // [0] in_frame
);

    t_geom                geom;
    logic                 r_in_valid;
    logic [C_COORD_W-1:0] r_column;
    logic [C_COORD_W-1:0] r_row;
    logic                 r_out_valid;
    logic                 advance;
    logic                 s_accept;

    // advance the held coordinate whenever the result register is free
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    cbpg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (geom)
    );

    // hold the coordinate until it moves into the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_column <= s_axis_tdata[11:0];
            r_row    <= s_axis_tdata[23:12];
        end
    end

    cbpg_shade u_shade (
        .i_clk      (i_clk),
        .i_load     (advance),
        .i_column   (r_column),
        .i_row      (r_row),
        .i_geom     (geom),
        .o_color    (m_axis_tdata),
        .o_in_frame (m_axis_tuser)
    );

    // result is valid from its load until the downstream transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;

    `CBPG_ASSERT_NOW(a_off_frame_black, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
    `CBPG_ASSERT_NEXT(a_accept_held, i_clk, i_rst_n, s_accept, r_in_valid)
    `CBPG_ASSERT_NEXT(a_advance_shows, i_clk, i_rst_n, advance, m_axis_tvalid)
    `CBPG_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !r_in_valid, s_axis_tready)

endmodule

### verif/color_bar_pattern_generator_tb.sv
// Self-checking testbench for the colour-bar pattern generator: random stream traffic and a colour predictor.
module color_bar_pattern_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbpg_pkg::*;

    // Expected outcome of one coordinate transfer.
    typedef struct packed {
        logic [23:0] color;
        logic        in_frame;
    } t_pixel;

    // Bar colours, kept apart from the RTL tables so a wrong entry there shows up.
    localparam logic [23:0] BOTTOM_BANDS [8] = '{
        24'h001d42, 24'hebebeb, 24'h2c005c, 24'h101010,
        24'h070707, 24'h101010, 24'h181818, 24'h101010
    };
    localparam logic [23:0] MIDDLE_BARS [7] = '{
        24'h0f0fb4, 24'h101010, 24'hb410b4, 24'h101010,
        24'h0db4b4, 24'h101010, 24'hb4b4b4
    };
    localparam logic [23:0] TOP_BARS [7] = '{
        24'hb4b4b4, 24'hb4b40c, 24'h0db4b4, 24'h0db40c,
        24'hb410b4, 24'hb40f0e, 24'h0f0fb4
    };

    localparam int unsigned DIM_CEILING   = 4096;
    localparam int          SIZE_STEPS    = 14;
    localparam int          PIXELS_A_SIZE = 125;

    // Predicts the colour of each accepted coordinate and compares the pixel stream.
    class bar_colour_checker;
        logic [C_DIM_W-1:0] width_reg;
        logic [C_DIM_W-1:0] height_reg;
        t_pixel             expected_pixels [$];
        int unsigned        coords_noted;
        int unsigned        pixels_checked;
        int unsigned        mismatches;

        function new();
            width_reg      = 13'd640;
            height_reg     = 13'd480;
            coords_noted   = 0;
            pixels_checked = 0;
            mismatches     = 0;
        endfunction

        function t_pixel bar_colour(logic [C_COORD_W-1:0] col, logic [C_COORD_W-1:0] row);
            int unsigned x;
            int unsigned y;
            int unsigned w;
            int unsigned h;
            bit          found;
            t_pixel      px;
            x = 32'(col);
            y = 32'(row);
            w = (32'(width_reg) > DIM_CEILING) ? DIM_CEILING : 32'(width_reg);
            h = (32'(height_reg) > DIM_CEILING) ? DIM_CEILING : 32'(height_reg);
            found = 1'b0;
            px.in_frame = 1'b1;
            if (x >= w || y >= h) begin
                px.color    = '0;
                px.in_frame = 1'b0;
                return px;
            end
            if (y < h / 4) begin
                px.color = BOTTOM_BANDS[7];
                for (int k = 1; k <= 4; k++) begin
                    if (!found && x < (w * k * 5 + 14) / 28) begin
                        px.color = BOTTOM_BANDS[k-1];
                        found    = 1'b1;
                    end
                end
                for (int k = 5; k <= 7; k++) begin
                    if (!found && x < (w * (k + 11) + 10) / 21) begin
                        px.color = BOTTOM_BANDS[k-1];
                        found    = 1'b1;
                    end
                end
            end else begin
                // first bar whose edge lies past the column wins, even if edges repeat
                px.color = (y < h / 3) ? MIDDLE_BARS[6] : TOP_BARS[6];
                for (int k = 1; k <= 7; k++) begin
                    if (!found && x < (w * k + 3) / 7) begin
                        px.color = (y < h / 3) ? MIDDLE_BARS[k-1] : TOP_BARS[k-1];
                        found    = 1'b1;
                    end
                end
            end
            return px;
        endfunction

        function void note_coordinate(logic [C_COORD_W-1:0] col, logic [C_COORD_W-1:0] row);
            expected_pixels.push_back(bar_colour(col, row));
            coords_noted++;
        endfunction

        task report_mismatch(string what);
            $display("%0t ns: pixel mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_pixel(logic [23:0] color, logic in_frame);
            t_pixel want;
            pixels_checked++;
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel %06h flag %0b", color, in_frame));
                return;
            end
            want = expected_pixels.pop_front();
            if (color !== want.color)
                report_mismatch($sformatf("colour %06h, want %06h", color, want.color));
            if (in_frame !== want.in_frame)
                report_mismatch($sformatf("in-frame flag %b, want %b", in_frame, want.in_frame));
        endtask

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [C_IDX_W-1:0] i_cfg_index;
    logic [C_DIM_W-1:0] i_cfg_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [23:0]        s_axis_tdata;   // [11:0] column, [23:12] row
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [23:0]        m_axis_tdata;   // [23:0] color
    logic               m_axis_tuser;   // [0] in_frame

    bar_colour_checker  bars;
    int unsigned        send_gap_pct;
    int unsigned        recv_stall_pct;
    int unsigned        sizes_used;

    color_bar_pattern_generator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Stall the pixel stream at random; the rate follows the current idling phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Watch both streams at the falling edge, when every signal has settled:
    // a transfer seen here completes at the next rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                bars.note_coordinate(s_axis_tdata[11:0], s_axis_tdata[23:12]);
            if (m_axis_tvalid && m_axis_tready)
                bars.check_pixel(m_axis_tdata, m_axis_tuser);
        end
    end

    // Offer one coordinate, idling first at the current rate, and hold it until taken.
    task send_coordinate(logic [C_COORD_W-1:0] col, logic [C_COORD_W-1:0] row);
        bit taken;
        while ($urandom_range(99, 0) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row, col};
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Drop valid and hold off until every pixel has come back, then let the pipe settle.
    task wait_for_pixels();
        s_axis_tvalid <= 1'b0;
        while (bars.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both size registers on consecutive edges; the block must be idle.
    task set_frame_size(logic [C_DIM_W-1:0] w, logic [C_DIM_W-1:0] h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= C_REG_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= C_REG_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        bars.width_reg  = w;
        bars.height_reg = h;
        sizes_used++;
    endtask

    // Mostly coordinates inside the frame, some right on its edges, the rest anywhere.
    task send_random_coordinate();
        int unsigned w;
        int unsigned h;
        int unsigned pick;
        logic [C_COORD_W-1:0] col;
        logic [C_COORD_W-1:0] row;
        w = (32'(bars.width_reg) > DIM_CEILING) ? DIM_CEILING : 32'(bars.width_reg);
        h = (32'(bars.height_reg) > DIM_CEILING) ? DIM_CEILING : 32'(bars.height_reg);
        pick = $urandom_range(7, 0);
        col = C_COORD_W'($urandom);
        row = C_COORD_W'($urandom);
        if (w != 0 && h != 0) begin
            if (pick >= 3) begin
                col = C_COORD_W'($urandom_range(w - 1, 0));
                row = C_COORD_W'($urandom_range(h - 1, 0));
            end else if (pick == 2) begin
                col = C_COORD_W'((w > 4095 || $urandom_range(1, 0) != 0) ? w - 1 : w);
                row = C_COORD_W'((h > 4095 || $urandom_range(1, 0) != 0) ? h - 1 : h);
            end
        end
        send_coordinate(col, row);
    endtask

    initial begin
        logic [C_DIM_W-1:0] width_plan  [SIZE_STEPS];
        logic [C_DIM_W-1:0] height_plan [SIZE_STEPS];

        bars           = new();
        send_gap_pct   = 21;
        recv_stall_pct = 55;
        sizes_used     = 1;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= C_REG_WIDTH;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pass at the reset size of 640 x 480: strip and band edges,
        // frame edges and the far corners of the coordinate space.
        send_coordinate(12'd0, 12'd0);
        send_coordinate(12'd113, 12'd0);
        send_coordinate(12'd114, 12'd0);
        send_coordinate(12'd639, 12'd0);
        send_coordinate(12'd640, 12'd0);
        send_coordinate(12'd0, 12'd119);
        send_coordinate(12'd0, 12'd120);
        send_coordinate(12'd90, 12'd140);
        send_coordinate(12'd91, 12'd159);
        send_coordinate(12'd0, 12'd160);
        send_coordinate(12'd548, 12'd300);
        send_coordinate(12'd549, 12'd300);
        send_coordinate(12'd639, 12'd479);
        send_coordinate(12'd0, 12'd480);
        send_coordinate(12'd4095, 12'd0);
        send_coordinate(12'd0, 12'd4095);
        send_coordinate(12'd4095, 12'd4095);
        send_coordinate(12'd2730, 12'd1365);

        // Size plan: unit, full, oversized and zero dimensions, tiny widths whose
        // edges collide, common video sizes and a few random ones.
        width_plan  = '{13'd1, 13'd4096, 13'd8191, 13'd0, 13'd640, 13'd2, 13'd7,
                        13'd1920, 13'd0, 13'd0, 13'd13, 13'd5000, 13'd0, 13'd640};
        height_plan = '{13'd1, 13'd4096, 13'd8191, 13'd480, 13'd0, 13'd3, 13'd4,
                        13'd1080, 13'd0, 13'd0, 13'd29, 13'd300, 13'd0, 13'd480};
        width_plan[8]   = C_DIM_W'($urandom_range(4096, 1));
        height_plan[8]  = C_DIM_W'($urandom_range(4096, 1));
        width_plan[9]   = C_DIM_W'($urandom_range(64, 1));
        height_plan[9]  = C_DIM_W'($urandom_range(4096, 1));
        width_plan[12]  = C_DIM_W'($urandom_range(4096, 1));
        height_plan[12] = C_DIM_W'($urandom_range(64, 1));

        for (int step = 0; step < SIZE_STEPS; step++) begin
            // Receiver stalls more than the sender idles first, then the other way round, then neither.
            if (step < 5) begin
                send_gap_pct   = 21;
                recv_stall_pct = 55;
            end else if (step < 10) begin
                send_gap_pct   = 55;
                recv_stall_pct = 21;
            end else begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            wait_for_pixels();
            set_frame_size(width_plan[step], height_plan[step]);
            for (int n = 0; n < PIXELS_A_SIZE; n++)
                send_random_coordinate();
        end

        wait_for_pixels();
        repeat (8) @(posedge i_clk);

        $display("Coverage: %0d coordinates over %0d frame sizes (zero, unit, full, oversized)",
                 bars.coords_noted, sizes_used);
        $display("Coverage: %0d pixels compared under three idling patterns", bars.pixels_checked);
        if (bars.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
